// ===== rtl/frame_bitmap_allocator_macros.svh =====
// Assertion macros for the frame bitmap allocator checker.
// Depends on clk and rst_n in the scope that uses them.
`ifndef FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FBA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame_bitmap_allocator: check failed");

// Next-cycle implication, disabled during reset.
`define FBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame_bitmap_allocator: check failed");

`endif

// ===== rtl/fba_pkg.sv =====
// Shared constants, codes and types of the frame bitmap allocator.
// No dependencies.
package fba_pkg;

    localparam int MAX_FRAMES  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int MAP_WORDS   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int FRAME_W     = 12;
    localparam int COUNT_W     = 13;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int CLS_W       = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 13'd4096;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEST  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_CHANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd2;

    localparam logic [CLS_W-1:0] CLS_ALLOC  = 3'd0;
    localparam logic [CLS_W-1:0] CLS_MAPPED = 3'd1;
    localparam logic [CLS_W-1:0] CLS_FREE   = 3'd2;
    localparam logic [CLS_W-1:0] CLS_TEST   = 3'd3;
    localparam logic [CLS_W-1:0] CLS_NONE   = 3'd4;

    typedef struct packed {
        logic [CLS_W-1:0]   cls;
        logic [FRAME_W-1:0] frame;
        logic               kernel;
        logic               writeable;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame_out;
        logic                present_bit;
        logic                rw_bit;
        logic                user_bit;
        logic                frame_in_use;
    } result_t;

    typedef struct packed {
        logic                  rd_en;
        logic [WORD_IDX_W-1:0] rd_addr;
        logic                  wr_en;
        logic [WORD_IDX_W-1:0] wr_addr;
        logic [WORD_BITS-1:0]  wr_data;
    } ram_req_t;

endpackage

// ===== rtl/fba_req_if.sv =====
// Request channel of the frame bitmap allocator.
// Depends on fba_pkg.
interface fba_req_if;
    logic                        valid;
    logic                        ready;
    logic [fba_pkg::CMD_W-1:0]   command;
    logic [fba_pkg::FRAME_W-1:0] frame_number;
    logic                        kernel_page;
    logic                        writeable_page;

    modport source (output valid, command, frame_number, kernel_page, writeable_page,
                    input ready);
    modport sink   (input valid, command, frame_number, kernel_page, writeable_page,
                    output ready);
endinterface

// ===== rtl/fba_rsp_if.sv =====
// Response channel of the frame bitmap allocator.
// Depends on fba_pkg.
interface fba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [fba_pkg::STATUS_W-1:0] status;
    logic [fba_pkg::FRAME_W-1:0]  frame_out;
    logic                         present_bit;
    logic                         rw_bit;
    logic                         user_bit;
    logic                         frame_in_use;

    modport source (output valid, status, frame_out, present_bit, rw_bit, user_bit,
                    frame_in_use, input ready);
    modport sink   (input valid, status, frame_out, present_bit, rw_bit, user_bit,
                    frame_in_use, output ready);
endinterface

// ===== rtl/fba_front.sv =====
// Front end: classifies request transactions and queues them for the back end.
// Depends on fba_pkg and fba_req_if.
module fba_front (
    input  logic            clk,
    input  logic            rst_n,
    fba_req_if.sink         req,
    output fba_pkg::entry_t pop_data,
    output logic            pop_valid,
    input  logic            pop_ready
);

    fba_pkg::entry_t                    queue_reg [fba_pkg::QUEUE_DEPTH];
    logic [fba_pkg::QIDX_W-1:0]         wr_ptr_reg;
    logic [fba_pkg::QIDX_W-1:0]         wr_ptr_next;
    logic [fba_pkg::QIDX_W-1:0]         rd_ptr_reg;
    logic [fba_pkg::QIDX_W-1:0]         rd_ptr_next;
    logic [fba_pkg::QCNT_W-1:0]         count_reg;
    logic [fba_pkg::QCNT_W-1:0]         count_next;
    fba_pkg::entry_t                    entry;
    logic                               push;
    logic                               pop;

    function automatic logic [fba_pkg::QIDX_W-1:0] ptr_inc(
        input logic [fba_pkg::QIDX_W-1:0] p
    );
        if (p == fba_pkg::QIDX_W'(fba_pkg::QUEUE_DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    always_comb
    begin
        entry.frame     = req.frame_number;
        entry.kernel    = req.kernel_page;
        entry.writeable = req.writeable_page;
        case (req.command)
            fba_pkg::CMD_ALLOC:
            begin
                entry.cls = (req.frame_number == '0) ? fba_pkg::CLS_ALLOC
                                                     : fba_pkg::CLS_MAPPED;
            end
            fba_pkg::CMD_FREE:
            begin
                entry.cls = (req.frame_number == '0) ? fba_pkg::CLS_NONE
                                                     : fba_pkg::CLS_FREE;
            end
            fba_pkg::CMD_TEST:
            begin
                entry.cls = fba_pkg::CLS_TEST;
            end
            default:
            begin
                entry.cls = fba_pkg::CLS_NONE;
            end
        endcase
    end

    assign req.ready = (count_reg != fba_pkg::QCNT_W'(fba_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = queue_reg[rd_ptr_reg];
    assign push      = req.valid && req.ready;
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= entry;
    end

endmodule

// ===== rtl/fba_bitmap_ram.sv =====
// Bitmap word memory, one write and one registered read port, per-word valid bits.
// Depends on fba_pkg.
module fba_bitmap_ram (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fba_pkg::ram_req_t                   ram_req,
    output logic [fba_pkg::WORD_BITS-1:0]       rd_data
);

    logic [fba_pkg::WORD_BITS-1:0] bitmap_mem [fba_pkg::MAP_WORDS];
    logic [fba_pkg::MAP_WORDS-1:0] word_valid_reg;
    logic [fba_pkg::WORD_BITS-1:0] rd_word_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ram_req.wr_en)
            bitmap_mem[ram_req.wr_addr] <= ram_req.wr_data;
        if (ram_req.rd_en)
            rd_word_reg <= bitmap_mem[ram_req.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (ram_req.wr_en)
                word_valid_reg[ram_req.wr_addr] <= 1'b1;
            if (ram_req.rd_en)
                rd_valid_reg <= word_valid_reg[ram_req.rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

// ===== rtl/fba_back.sv =====
// Back end: runs queued commands against the bitmap and holds the response.
// Depends on fba_pkg and fba_rsp_if.
module fba_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fba_pkg::entry_t                   pop_data,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  logic [fba_pkg::COUNT_W-1:0]       frame_count,
    output fba_pkg::ram_req_t                 ram_req,
    input  logic [fba_pkg::WORD_BITS-1:0]     rd_data,
    fba_rsp_if.source                         rsp
);

    localparam int STATE_W = 2;
    localparam logic [STATE_W-1:0] S_IDLE   = 2'd0;
    localparam logic [STATE_W-1:0] S_ACCESS = 2'd1;
    localparam logic [STATE_W-1:0] S_SCAN   = 2'd2;

    localparam int LIMW_W = fba_pkg::COUNT_W - fba_pkg::BIT_IDX_W;

    logic [STATE_W-1:0]                state_reg;
    logic [STATE_W-1:0]                state_next;
    fba_pkg::entry_t                   cur_reg;
    fba_pkg::entry_t                   cur_next;
    logic [fba_pkg::WORD_IDX_W-1:0]    scan_addr_reg;
    logic [fba_pkg::WORD_IDX_W-1:0]    scan_addr_next;
    logic [fba_pkg::WORD_IDX_W-1:0]    chk_addr_reg;
    logic [fba_pkg::WORD_IDX_W-1:0]    chk_addr_next;
    logic [fba_pkg::WORD_IDX_W-1:0]    last_word_reg;
    logic [fba_pkg::WORD_IDX_W-1:0]    last_word_next;
    fba_pkg::result_t                  out_reg;
    fba_pkg::result_t                  out_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;

    logic [fba_pkg::COUNT_W-1:0]       limit;
    logic [fba_pkg::COUNT_W-1:0]       limit_m1;
    logic [LIMW_W-1:0]                 limit_word;
    logic [fba_pkg::BIT_IDX_W-1:0]     limit_bit;
    logic [fba_pkg::WORD_BITS-1:0]     allowed;
    logic [fba_pkg::WORD_BITS-1:0]     free_bits;
    logic [fba_pkg::WORD_BITS-1:0]     lowest;
    logic [fba_pkg::BIT_IDX_W-1:0]     low_idx;
    logic [fba_pkg::BIT_IDX_W-1:0]     cur_bit;
    logic [fba_pkg::WORD_IDX_W-1:0]    cur_word;
    logic [fba_pkg::WORD_IDX_W-1:0]    pop_word;
    logic                              found;

    assign limit = (frame_count > fba_pkg::COUNT_W'(fba_pkg::MAX_FRAMES))
                   ? fba_pkg::COUNT_W'(fba_pkg::MAX_FRAMES) : frame_count;
    assign limit_m1   = limit - 1'b1;
    assign limit_word = limit[fba_pkg::COUNT_W-1:fba_pkg::BIT_IDX_W];
    assign limit_bit  = limit[fba_pkg::BIT_IDX_W-1:0];

    assign cur_bit  = cur_reg.frame[fba_pkg::BIT_IDX_W-1:0];
    assign cur_word = cur_reg.frame[fba_pkg::BIT_IDX_W +: fba_pkg::WORD_IDX_W];
    assign pop_word = pop_data.frame[fba_pkg::BIT_IDX_W +: fba_pkg::WORD_IDX_W];

    always_comb
    begin
        if (LIMW_W'(chk_addr_reg) < limit_word)
            allowed = '1;
        else if (LIMW_W'(chk_addr_reg) == limit_word)
            allowed = ~({fba_pkg::WORD_BITS{1'b1}} << limit_bit);
        else
            allowed = '0;
    end

    assign free_bits = ~rd_data & allowed;
    assign lowest    = free_bits & (~free_bits + 1'b1);
    assign found     = |free_bits;

    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < fba_pkg::WORD_BITS; i++)
        begin
            if (lowest[i])
                low_idx = low_idx | fba_pkg::BIT_IDX_W'(i);
        end
    end

    assign pop_ready = (state_reg == S_IDLE) && !out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        scan_addr_next = scan_addr_reg;
        chk_addr_next  = chk_addr_reg;
        last_word_next = last_word_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_req        = '0;

        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (pop_valid && pop_ready)
                begin
                    cur_next = pop_data;
                    out_next = '0;
                    case (pop_data.cls)
                        fba_pkg::CLS_MAPPED:
                        begin
                            out_next.status    = fba_pkg::ST_NO_CHANGE;
                            out_next.frame_out = pop_data.frame;
                            out_valid_next     = 1'b1;
                        end
                        fba_pkg::CLS_FREE, fba_pkg::CLS_TEST:
                        begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = pop_word;
                            state_next      = S_ACCESS;
                        end
                        fba_pkg::CLS_ALLOC:
                        begin
                            if (limit == '0)
                            begin
                                out_next.status = fba_pkg::ST_NO_FREE;
                                out_valid_next  = 1'b1;
                            end
                            else
                            begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = '0;
                                scan_addr_next  = fba_pkg::WORD_IDX_W'(1);
                                chk_addr_next   = '0;
                                last_word_next  = limit_m1[fba_pkg::BIT_IDX_W +:
                                                           fba_pkg::WORD_IDX_W];
                                state_next      = S_SCAN;
                            end
                        end
                        default:
                        begin
                            out_next.status = fba_pkg::ST_NO_CHANGE;
                            out_valid_next  = 1'b1;
                        end
                    endcase
                end
            end
            S_ACCESS:
            begin
                out_next.status = fba_pkg::ST_DONE;
                out_valid_next  = 1'b1;
                state_next      = S_IDLE;
                if (cur_reg.cls == fba_pkg::CLS_FREE)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = cur_word;
                    ram_req.wr_data = rd_data & ~(fba_pkg::WORD_BITS'(1) << cur_bit);
                end
                else
                begin
                    out_next.frame_in_use = rd_data[cur_bit];
                end
            end
            S_SCAN:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = scan_addr_reg;
                if (found)
                begin
                    ram_req.wr_en        = 1'b1;
                    ram_req.wr_addr      = chk_addr_reg;
                    ram_req.wr_data      = rd_data | lowest;
                    out_next.status      = fba_pkg::ST_DONE;
                    out_next.frame_out   = fba_pkg::FRAME_W'({chk_addr_reg, low_idx});
                    out_next.present_bit = 1'b1;
                    out_next.rw_bit      = cur_reg.writeable;
                    out_next.user_bit    = ~cur_reg.kernel;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
                else if (chk_addr_reg == last_word_reg)
                begin
                    out_next.status = fba_pkg::ST_NO_FREE;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    chk_addr_next  = scan_addr_reg;
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        scan_addr_reg <= scan_addr_next;
        chk_addr_reg  <= chk_addr_next;
        last_word_reg <= last_word_next;
        out_reg       <= out_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_reg.status;
    assign rsp.frame_out    = out_reg.frame_out;
    assign rsp.present_bit  = out_reg.present_bit;
    assign rsp.rw_bit       = out_reg.rw_bit;
    assign rsp.user_bit     = out_reg.user_bit;
    assign rsp.frame_in_use = out_reg.frame_in_use;

endmodule

// ===== rtl/frame_bitmap_allocator.sv =====
// Frame bitmap allocator: one transaction at a time through a 2-entry queue.
// No-op, mapped and no-count cases answer without a memory access; free and test
// read one bitmap word, and allocate scans up to 128 words, one bitmap word per
// cycle through the memory read port. A new transaction is taken only after the
// last response is accepted. Reset (rst_n low, async) clears per-word valid bits
// at once, so the bitmap reads all free with no clearing pass; frame_count resets to 4096.
module frame_bitmap_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    fba_req_if.sink                       req,
    fba_rsp_if.source                     rsp,
    input  logic                          cfg_write_en,
    input  logic [fba_pkg::COUNT_W-1:0]   cfg_write_data
);

    logic [fba_pkg::COUNT_W-1:0]   frame_count_reg;
    fba_pkg::entry_t               pop_data;
    logic                          pop_valid;
    logic                          pop_ready;
    fba_pkg::ram_req_t             ram_req;
    logic [fba_pkg::WORD_BITS-1:0] rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_count_reg <= fba_pkg::FRAME_COUNT_RESET;
        else if (cfg_write_en)
            frame_count_reg <= cfg_write_data;
    end

    fba_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .pop_data  (pop_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready)
    );

    fba_bitmap_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .ram_req (ram_req),
        .rd_data (rd_data)
    );

    fba_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_data    (pop_data),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .frame_count (frame_count_reg),
        .ram_req     (ram_req),
        .rd_data     (rd_data),
        .rsp         (rsp)
    );

endmodule

// ===== rtl/fba_checker.sv =====
// Port-level checks of the frame bitmap allocator response channel, bound to the top.
// Depends on fba_pkg and frame_bitmap_allocator_macros.svh.
`include "frame_bitmap_allocator_macros.svh"

module fba_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [fba_pkg::STATUS_W-1:0] rsp_status,
    input logic [fba_pkg::FRAME_W-1:0]  rsp_frame_out,
    input logic                         rsp_present_bit,
    input logic                         rsp_rw_bit,
    input logic                         rsp_user_bit,
    input logic                         rsp_frame_in_use
);

    logic [fba_pkg::STATUS_W+fba_pkg::FRAME_W+3:0] rsp_bits;
    logic                                          status_legal;
    logic                                          present_ok;
    logic                                          no_free;
    logic                                          no_free_clean;

    assign rsp_bits = {rsp_status, rsp_frame_out, rsp_present_bit, rsp_rw_bit,
                       rsp_user_bit, rsp_frame_in_use};

    assign status_legal  = (rsp_status == fba_pkg::ST_DONE)
                           || (rsp_status == fba_pkg::ST_NO_CHANGE)
                           || (rsp_status == fba_pkg::ST_NO_FREE);
    assign present_ok    = (rsp_status == fba_pkg::ST_DONE) && !rsp_frame_in_use;
    assign no_free       = rsp_valid && (rsp_status == fba_pkg::ST_NO_FREE);
    assign no_free_clean = (rsp_frame_out == '0) && !rsp_present_bit && !rsp_rw_bit
                           && !rsp_user_bit && !rsp_frame_in_use;

    `FBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bits))
    `FBA_ASSERT_IMPLY(a_status_legal, rsp_valid, status_legal)
    `FBA_ASSERT_IMPLY(a_present_done, rsp_valid && rsp_present_bit, present_ok)
    `FBA_ASSERT_IMPLY(a_no_free_clean, no_free, no_free_clean)

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_frame_out    (rsp.frame_out),
    .rsp_present_bit  (rsp.present_bit),
    .rsp_rw_bit       (rsp.rw_bit),
    .rsp_user_bit     (rsp.user_bit),
    .rsp_frame_in_use (rsp.frame_in_use)
);

// ===== tb/sv/frame_bitmap_allocator_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the frame bitmap allocator: watches the request, response and
// configuration ports, predicts every response from its own bitmap and compares.
// Depends on fba_pkg, fba_req_if and fba_rsp_if.
module frame_bitmap_allocator_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    fba_req_if                          req,
    fba_rsp_if                          rsp,
    input  logic                        cfg_write_en,
    input  logic [fba_pkg::COUNT_W-1:0] cfg_write_data,
    output int unsigned                 mismatch_count,
    output int unsigned                 responses_pending
);

    logic [fba_pkg::WORD_BITS-1:0] used_map [fba_pkg::MAP_WORDS];
    logic [fba_pkg::COUNT_W-1:0]   managed_frames;
    fba_pkg::result_t              expected_q [$];
    int unsigned                   errors;

    function automatic logic frame_used(input logic [fba_pkg::FRAME_W-1:0] fr);
        return used_map[fr[fba_pkg::FRAME_W-1:fba_pkg::BIT_IDX_W]]
                       [fr[fba_pkg::BIT_IDX_W-1:0]];
    endfunction

    function automatic fba_pkg::result_t service_request(
        input logic [fba_pkg::CMD_W-1:0]   cmd,
        input logic [fba_pkg::FRAME_W-1:0] fr,
        input logic                        kern,
        input logic                        wr
    );
        fba_pkg::result_t            res;
        int                          limit;
        int                          pick;
        logic [fba_pkg::FRAME_W-1:0] got;
        res   = '0;
        limit = (managed_frames > fba_pkg::MAX_FRAMES) ? fba_pkg::MAX_FRAMES
                                                       : int'(managed_frames);
        pick  = -1;
        got   = '0;
        case (cmd)
            fba_pkg::CMD_ALLOC:
            begin
                if (fr != '0)
                begin
                    res.status    = fba_pkg::ST_NO_CHANGE;
                    res.frame_out = fr;
                end
                else
                begin
                    for (int f = 0; f < limit; f++)
                    begin
                        if (!frame_used(f[fba_pkg::FRAME_W-1:0]))
                        begin
                            pick = f;
                            break;
                        end
                    end
                    if (pick < 0)
                    begin
                        res.status = fba_pkg::ST_NO_FREE;
                    end
                    else
                    begin
                        got = pick[fba_pkg::FRAME_W-1:0];
                        used_map[got[fba_pkg::FRAME_W-1:fba_pkg::BIT_IDX_W]]
                                [got[fba_pkg::BIT_IDX_W-1:0]] = 1'b1;
                        res.status      = fba_pkg::ST_DONE;
                        res.frame_out   = got;
                        res.present_bit = 1'b1;
                        res.rw_bit      = wr;
                        res.user_bit    = ~kern;
                    end
                end
            end
            fba_pkg::CMD_FREE:
            begin
                if (fr == '0)
                begin
                    res.status = fba_pkg::ST_NO_CHANGE;
                end
                else
                begin
                    used_map[fr[fba_pkg::FRAME_W-1:fba_pkg::BIT_IDX_W]]
                            [fr[fba_pkg::BIT_IDX_W-1:0]] = 1'b0;
                    res.status = fba_pkg::ST_DONE;
                end
            end
            fba_pkg::CMD_TEST:
            begin
                res.status       = fba_pkg::ST_DONE;
                res.frame_in_use = frame_used(fr);
            end
            default:
            begin
                res.status = fba_pkg::ST_NO_CHANGE;
            end
        endcase
        return res;
    endfunction

    function automatic void compare_field(input string       field,
                                          input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fba_pkg::result_t want;
        if (!rst_n)
        begin
            for (int w = 0; w < fba_pkg::MAP_WORDS; w++)
            begin
                used_map[w] = '0;
            end
            managed_frames = fba_pkg::FRAME_COUNT_RESET;
            expected_q.delete();
            errors = 0;
            mismatch_count    <= 0;
            responses_pending <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                managed_frames = cfg_write_data;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("response with nothing outstanding: status %0d, frame_out %0d",
                           rsp.status, rsp.frame_out);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("status", 32'(want.status), 32'(rsp.status));
                    compare_field("frame_out", 32'(want.frame_out), 32'(rsp.frame_out));
                    compare_field("present_bit", 32'(want.present_bit),
                                  32'(rsp.present_bit));
                    compare_field("rw_bit", 32'(want.rw_bit), 32'(rsp.rw_bit));
                    compare_field("user_bit", 32'(want.user_bit), 32'(rsp.user_bit));
                    compare_field("frame_in_use", 32'(want.frame_in_use),
                                  32'(rsp.frame_in_use));
                end
            end
            if (req.valid && req.ready)
            begin
                expected_q.push_back(service_request(req.command, req.frame_number,
                                                     req.kernel_page, req.writeable_page));
            end
            mismatch_count    <= errors;
            responses_pending <= $unsigned(expected_q.size());
        end
    end

endmodule

// ===== tb/sv/frame_bitmap_allocator_tb.sv =====
`timescale 1ns / 100ps
// Top of the frame bitmap allocator testbench: clock, reset, directed and random
// requests, frame_count writes, response back-pressure and the final verdict.
// Depends on fba_pkg, the channel interfaces, the allocator and its checker.
module frame_bitmap_allocator_tb;

    localparam int unsigned               CYCLE_LIMIT     = 600000;
    localparam int unsigned               LONG_STALL      = 60;
    localparam int unsigned               CFG_SETTLE      = 4;
    localparam int unsigned               END_SETTLE      = 140;
    localparam int unsigned               ITEMS_PER_PHASE = 50;
    localparam logic [fba_pkg::CMD_W-1:0] CMD_UNUSED      = 2'd3;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_write_en;
    logic [fba_pkg::COUNT_W-1:0] cfg_write_data;
    int unsigned                 mismatch_count;
    int unsigned                 responses_pending;
    int unsigned                 cycle_count = 0;
    bit                          idle_on;
    bit                          long_stall_req;
    int unsigned                 sent_by_cmd [4];
    int unsigned                 settings_used;

    fba_req_if req_ch();
    fba_rsp_if rsp_ch();

    frame_bitmap_allocator i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    frame_bitmap_allocator_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .req               (req_ch),
        .rsp               (rsp_ch),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .mismatch_count    (mismatch_count),
        .responses_pending (responses_pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Response side: short random stalls, plus one long hold-off on request.
    initial
    begin
        int unsigned stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                stall_left     = LONG_STALL;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 3);
            end
            if (stall_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_transaction(input logic [fba_pkg::CMD_W-1:0]   cmd,
                                    input logic [fba_pkg::FRAME_W-1:0] fr,
                                    input logic                        kp,
                                    input logic                        wp);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.command        <= cmd;
        req_ch.frame_number   <= fr;
        req_ch.kernel_page    <= kp;
        req_ch.writeable_page <= wp;
        sent_by_cmd[cmd]++;
        @(posedge clk iff req_ch.ready);
    endtask

    // Hold the request side until every response is back.
    task automatic drain(input int unsigned settle);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (responses_pending != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_frame_count(input logic [fba_pkg::COUNT_W-1:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        logic [fba_pkg::COUNT_W-1:0] phase_counts [9];
        int unsigned                 window;
        int unsigned                 roll;
        logic [fba_pkg::CMD_W-1:0]   cmd;
        logic [fba_pkg::FRAME_W-1:0] fr;

        phase_counts = '{13'd35, 13'd4096, 13'd100, 13'd1, 13'd8191, 13'd70, 13'd0,
                         13'd4096, 13'd300};
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.command        = fba_pkg::CMD_ALLOC;
        req_ch.frame_number   = '0;
        req_ch.kernel_page    = 1'b0;
        req_ch.writeable_page = 1'b0;
        cfg_write_en          = 1'b0;
        cfg_write_data        = '0;
        idle_on               = 1'b0;
        long_stall_req        = 1'b0;
        settings_used         = 0;
        foreach (sent_by_cmd[c])
        begin
            sent_by_cmd[c] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_transaction(fba_pkg::CMD_TEST, 12'd0, 1'b0, 1'b0);
        send_transaction(fba_pkg::CMD_TEST, 12'd4095, 1'b1, 1'b1);
        send_transaction(fba_pkg::CMD_ALLOC, 12'd0, 1'b0, 1'b1);
        send_transaction(fba_pkg::CMD_ALLOC, 12'd0, 1'b1, 1'b0);
        send_transaction(fba_pkg::CMD_ALLOC, 12'd4095, 1'b1, 1'b1);
        send_transaction(fba_pkg::CMD_TEST, 12'd0, 1'b0, 1'b0);
        send_transaction(fba_pkg::CMD_FREE, 12'd0, 1'b1, 1'b1);
        send_transaction(fba_pkg::CMD_FREE, 12'd1, 1'b0, 1'b0);
        send_transaction(fba_pkg::CMD_TEST, 12'd1, 1'b0, 1'b0);
        send_transaction(CMD_UNUSED, 12'd4095, 1'b1, 1'b1);
        send_transaction(fba_pkg::CMD_ALLOC, 12'd0, 1'b1, 1'b1);

        drain(CFG_SETTLE);
        write_frame_count(13'd0);
        send_transaction(fba_pkg::CMD_ALLOC, 12'd0, 1'b0, 1'b1);
        send_transaction(fba_pkg::CMD_FREE, 12'd4095, 1'b0, 1'b0);

        drain(CFG_SETTLE);
        write_frame_count(13'd8191);
        send_transaction(fba_pkg::CMD_ALLOC, 12'd0, 1'b0, 1'b0);

        drain(CFG_SETTLE);
        write_frame_count(13'd4);
        send_transaction(fba_pkg::CMD_ALLOC, 12'd0, 1'b1, 1'b0);
        send_transaction(fba_pkg::CMD_ALLOC, 12'd0, 1'b0, 1'b1);
        send_transaction(fba_pkg::CMD_TEST, 12'd3, 1'b0, 1'b0);
        send_transaction(fba_pkg::CMD_FREE, 12'd2, 1'b0, 1'b0);
        send_transaction(fba_pkg::CMD_ALLOC, 12'd0, 1'b0, 1'b0);

        foreach (phase_counts[p])
        begin
            drain(CFG_SETTLE);
            write_frame_count(phase_counts[p]);
            idle_on = (p % 2 == 0) && (p < 7);
            if (p == 1)
            begin
                long_stall_req = 1'b1;
            end
            if (phase_counts[p] == '0)
                window = 16;
            else if (phase_counts[p] < 13'd512)
                window = 32'(phase_counts[p]) + 32'd8;
            else
                window = 512;
            repeat (ITEMS_PER_PHASE)
            begin
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 4) == 0)
                    fr = fba_pkg::FRAME_W'($urandom_range(1, 4095));
                else
                    fr = fba_pkg::FRAME_W'($urandom_range(1, window));
                if (roll < 45)
                begin
                    cmd = fba_pkg::CMD_ALLOC;
                    fr  = '0;
                end
                else if (roll < 55)
                begin
                    cmd = fba_pkg::CMD_ALLOC;
                end
                else if (roll < 78)
                begin
                    cmd = fba_pkg::CMD_FREE;
                end
                else if (roll < 95)
                begin
                    cmd = fba_pkg::CMD_TEST;
                    if ($urandom_range(0, 9) == 0)
                        fr = '0;
                end
                else
                begin
                    cmd = CMD_UNUSED;
                    fr  = fba_pkg::FRAME_W'($urandom_range(0, 4095));
                end
                send_transaction(cmd, fr, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
            end
        end

        drain(END_SETTLE);
        $display("Sent %0d alloc, %0d free, %0d test and %0d unused-code transactions",
                 sent_by_cmd[fba_pkg::CMD_ALLOC], sent_by_cmd[fba_pkg::CMD_FREE],
                 sent_by_cmd[fba_pkg::CMD_TEST], sent_by_cmd[CMD_UNUSED]);
        $display("across %0d frame_count settings, with and without back-pressure.",
                 settings_used);
        if (mismatch_count == 0 && responses_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fba_pkg.sv
rtl/fba_req_if.sv
rtl/fba_rsp_if.sv
rtl/fba_front.sv
rtl/fba_bitmap_ram.sv
rtl/fba_back.sv
rtl/frame_bitmap_allocator.sv
rtl/fba_checker.sv
tb/sv/frame_bitmap_allocator_checker.sv
tb/sv/frame_bitmap_allocator_tb.sv
